FILE: hdl/seg_pkg.sv
package seg_pkg;

  // orientation of an ordered point triple
  typedef enum logic [1:0] {
    ORIENT_COL = 2'd0,
    ORIENT_CW  = 2'd1,
    ORIENT_CCW = 2'd2
  } orient_t;

  // the four orientations of one segment pair
  typedef struct packed {
    orient_t o1;  // b start against line a
    orient_t o2;  // b end against line a
    orient_t o3;  // a start against line b
    orient_t o4;  // a end against line b
  } orient_set_t;

  // endpoint inside the other segment's bounding box
  typedef struct packed {
    logic b_start_in_a;
    logic b_end_in_a;
    logic a_start_in_b;
    logic a_end_in_b;
  } box_set_t;

  localparam int NUM_ORIENT = 4;

endpackage

FILE: hdl/seg_diff.sv
module seg_diff import seg_pkg::*; #(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] ax0,
  input  logic signed [W-1:0] ay0,
  input  logic signed [W-1:0] ax1,
  input  logic signed [W-1:0] ay1,
  input  logic signed [W-1:0] bx0,
  input  logic signed [W-1:0] by0,
  input  logic signed [W-1:0] bx1,
  input  logic signed [W-1:0] by1,
  output logic                out_valid,
  output logic signed [W:0]   ma [NUM_ORIENT],
  output logic signed [W:0]   mb [NUM_ORIENT],
  output logic signed [W:0]   mc [NUM_ORIENT],
  output logic signed [W:0]   md [NUM_ORIENT],
  output box_set_t            box
);

  localparam int DW = W + 1;

  // q lies between p and r on one axis
  function automatic logic between(input logic signed [W-1:0] q,
                                   input logic signed [W-1:0] p,
                                   input logic signed [W-1:0] r);
    between = (q >= p && q <= r) || (q >= r && q <= p);
  endfunction

  function automatic logic signed [W:0] sub(input logic signed [W-1:0] x,
                                            input logic signed [W-1:0] y);
    sub = DW'(x) - DW'(y);
  endfunction

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // coordinate differences, cross = ma*mb - mc*md for each orientation
  always_ff @(posedge clk) begin
    ma[0] <= sub(ay1, ay0);
    mb[0] <= sub(bx0, ax1);
    mc[0] <= sub(ax1, ax0);
    md[0] <= sub(by0, ay1);

    ma[1] <= sub(ay1, ay0);
    mb[1] <= sub(bx1, ax1);
    mc[1] <= sub(ax1, ax0);
    md[1] <= sub(by1, ay1);

    ma[2] <= sub(by1, by0);
    mb[2] <= sub(ax0, bx1);
    mc[2] <= sub(bx1, bx0);
    md[2] <= sub(ay0, by1);

    ma[3] <= sub(by1, by0);
    mb[3] <= sub(ax1, bx1);
    mc[3] <= sub(bx1, bx0);
    md[3] <= sub(ay1, by1);
  end

  // bounding box checks
  always_ff @(posedge clk) begin
    box.b_start_in_a <= between(bx0, ax0, ax1) && between(by0, ay0, ay1);
    box.b_end_in_a   <= between(bx1, ax0, ax1) && between(by1, ay0, ay1);
    box.a_start_in_b <= between(ax0, bx0, bx1) && between(ay0, by0, by1);
    box.a_end_in_b   <= between(ax1, bx0, bx1) && between(ay1, by0, by1);
  end

endmodule

FILE: hdl/seg_orient.sv
module seg_orient import seg_pkg::*; #(
  parameter int W = 16
) (
  input  logic            clk,
  input  logic signed [W:0] a,
  input  logic signed [W:0] b,
  input  logic signed [W:0] c,
  input  logic signed [W:0] d,
  output orient_t         orient
);

  localparam int PW = 2 * W + 2;
  localparam int XW = PW + 1;

  logic signed [PW-1:0] prod_p;
  logic signed [PW-1:0] prod_q;
  logic signed [XW-1:0] xprod;

  // products
  always_ff @(posedge clk) begin
    prod_p <= a * b;
    prod_q <= c * d;
  end

  // exact cross product and its sign
  assign xprod = XW'(prod_p) - XW'(prod_q);

  always_ff @(posedge clk) begin
    if (xprod == '0) begin
      orient <= ORIENT_COL;
    end else if (xprod[XW-1]) begin
      orient <= ORIENT_CCW;
    end else begin
      orient <= ORIENT_CW;
    end
  end

endmodule

FILE: hdl/seg_decide.sv
module seg_decide import seg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  orient_set_t orients,
  input  box_set_t    box,
  output logic        done,
  output logic        segments_meet
);

  logic meet_next;

  // proper crossing, or a collinear endpoint inside the other box
  always_comb begin
    meet_next = (orients.o1 != orients.o2 && orients.o3 != orients.o4)
             || (orients.o1 == ORIENT_COL && box.b_start_in_a)
             || (orients.o2 == ORIENT_COL && box.b_end_in_a)
             || (orients.o3 == ORIENT_COL && box.a_start_in_b)
             || (orients.o4 == ORIENT_COL && box.a_end_in_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    segments_meet <= meet_next;
  end

endmodule

FILE: hdl/segment_intersection_test.sv
// Segment intersection test. A pair of 2-D segments is taken whenever start
// is high; busy is always low, so a new pair may be given in every cycle.
// Each pair yields one segments_meet word, shown for exactly one cycle with
// done high, in the order taken. The register stages are: coordinate
// differences and bounding box compares, the eight cross-product
// multipliers, the subtract and sign of each cross product, and the final
// decision. Results cannot be held off; the receiver must take each word
// when done is high.
module segment_intersection_test import seg_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a_start_x,
  input  logic signed [COORD_WIDTH-1:0] a_start_y,
  input  logic signed [COORD_WIDTH-1:0] a_end_x,
  input  logic signed [COORD_WIDTH-1:0] a_end_y,
  input  logic signed [COORD_WIDTH-1:0] b_start_x,
  input  logic signed [COORD_WIDTH-1:0] b_start_y,
  input  logic signed [COORD_WIDTH-1:0] b_end_x,
  input  logic signed [COORD_WIDTH-1:0] b_end_y,
  output logic                          done,
  output logic                          segments_meet
);

  localparam int W = COORD_WIDTH;

  logic                s1_valid;
  logic signed [W:0]   ma [NUM_ORIENT];
  logic signed [W:0]   mb [NUM_ORIENT];
  logic signed [W:0]   mc [NUM_ORIENT];
  logic signed [W:0]   md [NUM_ORIENT];
  box_set_t            s1_box;
  box_set_t            s2_box;
  box_set_t            s3_box;
  logic                s2_valid;
  logic                s3_valid;
  orient_t             orient [NUM_ORIENT];
  orient_set_t         orients;

  // the pipeline never stalls
  assign busy = 1'b0;

  // stage 1: differences and box compares
  seg_diff #(.W(W)) u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .ax0       (a_start_x),
    .ay0       (a_start_y),
    .ax1       (a_end_x),
    .ay1       (a_end_y),
    .bx0       (b_start_x),
    .by0       (b_start_y),
    .bx1       (b_end_x),
    .by1       (b_end_y),
    .out_valid (s1_valid),
    .ma        (ma),
    .mb        (mb),
    .mc        (mc),
    .md        (md),
    .box       (s1_box)
  );

  // stages 2 and 3: products, then orientation sign
  for (genvar i = 0; i < NUM_ORIENT; i++) begin : g_orient
    seg_orient #(.W(W)) u_orient (
      .clk    (clk),
      .a      (ma[i]),
      .b      (mb[i]),
      .c      (mc[i]),
      .d      (md[i]),
      .orient (orient[i])
    );
  end

  assign orients = '{o1: orient[0], o2: orient[1], o3: orient[2], o4: orient[3]};

  // valid and box flags follow the orientation stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_box <= s1_box;
    s3_box <= s2_box;
  end

  // stage 4: decision and output word
  seg_decide u_decide (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s3_valid),
    .orients       (orients),
    .box           (s3_box),
    .done          (done),
    .segments_meet (segments_meet)
  );

`ifndef SYNTHESIS
  // every taken pair gives a word after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done)
    else $error("accepted pair gave no result");

  // no word without a pair taken earlier
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without accepted pair");

  // a shared start point always meets
  a_shared_point: assert property (@(posedge clk) disable iff (rst)
    start && !busy && a_start_x == b_start_x && a_start_y == b_start_y
    |-> ##4 segments_meet)
    else $error("shared endpoint not reported as meeting");

  // a shared end point always meets
  a_shared_end: assert property (@(posedge clk) disable iff (rst)
    start && !busy && a_end_x == b_end_x && a_end_y == b_end_y
    |-> ##4 segments_meet)
    else $error("shared end point not reported as meeting");
`endif

endmodule

FILE: tb/segment_intersection_test_tb.sv
module segment_intersection_test_tb;
  import seg_pkg::*;

  localparam int COORD_WIDTH = 16;
  localparam int RANDOM_PAIRS = 850;
  localparam int DIRECTED_ROWS = 20;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one segment pair as plain integers
  typedef struct {
    int ax0, ay0, ax1, ay1;
    int bx0, by0, bx1, by1;
  } seg_pair_t;

  // directed row: pair plus an optional typed-in answer
  typedef struct {
    seg_pair_t seg;
    bit        fixed;
    bit        meet;
  } plan_row_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  coord_t a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  coord_t b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic   done;
  logic   segments_meet;

  // answer source travels with the word on the input ports
  bit row_fixed = 1'b0;
  bit row_meet = 1'b0;
  bit steady = 1'b0;

  bit meet_expected[$];
  int errors = 0;
  int results_checked = 0;
  int meets_seen = 0;

  plan_row_t plan [DIRECTED_ROWS] = '{
    // equal points at the most negative corner
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1, 1'b1},
    // equal points at the most positive corner
    '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b1, 1'b1},
    // full-range diagonals crossing at the middle
    '{'{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}, 1'b1, 1'b1},
    // full-range parallel horizontals
    '{'{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}, 1'b1, 1'b0},
    // collinear and overlapping
    '{'{0, 0, 10, 10, 5, 5, 20, 20}, 1'b1, 1'b1},
    // collinear and disjoint
    '{'{0, 0, 4, 4, 6, 6, 9, 9}, 1'b1, 1'b0},
    // touching at an endpoint
    '{'{0, 0, 5, 0, 5, 0, 5, 7}, 1'b1, 1'b1},
    // t junction
    '{'{-5, 0, 5, 0, 0, 0, 0, 9}, 1'b0, 1'b0},
    // degenerate segment lying on the other one
    '{'{3, 3, 3, 3, 0, 0, 6, 6}, 1'b1, 1'b1},
    // degenerate segment off the other one
    '{'{3, 4, 3, 4, 0, 0, 6, 6}, 1'b1, 1'b0},
    // two equal points
    '{'{7, -2, 7, -2, 7, -2, 7, -2}, 1'b1, 1'b1},
    // two distinct points
    '{'{1, 1, 1, 1, 2, 2, 2, 2}, 1'b1, 1'b0},
    // collinear halves of the x axis with a one-step gap
    '{'{-32768, 0, 0, 0, 1, 0, 32767, 0}, 1'b1, 1'b0},
    // short piece inside the full-range diagonal
    '{'{-32768, -32768, 32767, 32767, -1, -1, 0, 0}, 1'b1, 1'b1},
    // full-height vertical containing a short one
    '{'{2, -32768, 2, 32767, 2, 0, 2, 5}, 1'b1, 1'b1},
    // near miss short of the crossing point
    '{'{0, 0, 10, 10, 0, 10, 4, 6}, 1'b0, 1'b0},
    // full-range anti-diagonal against a corner stub
    '{'{-32768, 32767, 32767, -32768, -32768, -32768, -32767, -32767}, 1'b0, 1'b0},
    // crossing between lattice points
    '{'{-1, 0, 0, -1, 0, 0, -1, -1}, 1'b0, 1'b0},
    // reversed endpoints of the touching case
    '{'{5, 0, 0, 0, 5, 7, 5, 0}, 1'b0, 1'b0},
    // collinear segments sharing one endpoint
    '{'{0, 0, 3, 0, 3, 0, 8, 0}, 1'b1, 1'b1}
  };

  segment_intersection_test #(
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .a_start_x    (a_start_x),
    .a_start_y    (a_start_y),
    .a_end_x      (a_end_x),
    .a_end_y      (a_end_y),
    .b_start_x    (b_start_x),
    .b_start_y    (b_start_y),
    .b_end_x      (b_end_x),
    .b_end_y      (b_end_y),
    .done         (done),
    .segments_meet(segments_meet)
  );

  always #5 clk = ~clk;

  // turn direction of p -> q -> r from the exact cross product
  function automatic orient_t turn_of(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
    longint xprod;
    xprod = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
    if (xprod == 0) return ORIENT_COL;
    if (xprod > 0) return ORIENT_CW;
    return ORIENT_CCW;
  endfunction

  // q inside the axis-aligned box spanned by p and r
  function automatic bit within_box(longint px, longint py, longint qx, longint qy,
                                    longint rx, longint ry);
    longint xlo, xhi, ylo, yhi;
    xlo = (px < rx) ? px : rx;
    xhi = (px < rx) ? rx : px;
    ylo = (py < ry) ? py : ry;
    yhi = (py < ry) ? ry : py;
    return (qx >= xlo) && (qx <= xhi) && (qy >= ylo) && (qy <= yhi);
  endfunction

  function automatic bit pair_meets(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                                    coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
    orient_set_t t;
    t.o1 = turn_of(ax0, ay0, ax1, ay1, bx0, by0);
    t.o2 = turn_of(ax0, ay0, ax1, ay1, bx1, by1);
    t.o3 = turn_of(bx0, by0, bx1, by1, ax0, ay0);
    t.o4 = turn_of(bx0, by0, bx1, by1, ax1, ay1);
    if (t.o1 != t.o2 && t.o3 != t.o4) return 1'b1;
    if (t.o1 == ORIENT_COL && within_box(ax0, ay0, bx0, by0, ax1, ay1)) return 1'b1;
    if (t.o2 == ORIENT_COL && within_box(ax0, ay0, bx1, by1, ax1, ay1)) return 1'b1;
    if (t.o3 == ORIENT_COL && within_box(bx0, by0, ax0, ay0, bx1, by1)) return 1'b1;
    if (t.o4 == ORIENT_COL && within_box(bx0, by0, ax1, ay1, bx1, by1)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int pick(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // random pair, weighted toward collinear, touching and degenerate shapes
  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int px, py, dx, dy, r;
    px = pick(-1000, 1000);
    py = pick(-1000, 1000);
    dx = pick(-4, 4);
    dy = pick(-4, 4);
    case ($urandom_range(9))
      0, 1: begin
        s = '{pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
              pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
              pick(-32768, 32767), pick(-32768, 32767)};
      end
      2, 3: begin
        s = '{pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8),
              pick(-8, 8), pick(-8, 8), pick(-8, 8), pick(-8, 8)};
      end
      4, 5: begin
        // all four endpoints on one line through p
        s.ax0 = px + pick(-6, 6) * dx;
        s.ay0 = py;
        s.ay0 = (s.ax0 - px) * 0 + py;
        r = pick(-6, 6);
        s.ax0 = px + r * dx;  s.ay0 = py + r * dy;
        r = pick(-6, 6);
        s.ax1 = px + r * dx;  s.ay1 = py + r * dy;
        r = pick(-6, 6);
        s.bx0 = px + r * dx;  s.by0 = py + r * dy;
        r = pick(-6, 6);
        s.bx1 = px + r * dx;  s.by1 = py + r * dy;
      end
      6: begin
        // shared endpoint
        s = '{pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
              pick(-32768, 32767), 0, 0, pick(-32768, 32767), pick(-32768, 32767)};
        if ($urandom_range(1)) begin
          s.bx0 = s.ax1;  s.by0 = s.ay1;
        end else begin
          s.bx0 = s.ax0;  s.by0 = s.ay0;
        end
      end
      7: begin
        // degenerate a, either on b or somewhere nearby
        r = pick(-6, 6);
        s.bx0 = px - 6 * dx;  s.by0 = py - 6 * dy;
        s.bx1 = px + 6 * dx;  s.by1 = py + 6 * dy;
        s.ax0 = px + r * dx + ($urandom_range(1) ? pick(-2, 2) : 0);
        s.ay0 = py + r * dy;
        s.ax1 = s.ax0;  s.ay1 = s.ay0;
      end
      8: begin
        s = '{pick_edge(), pick_edge(), pick_edge(), pick_edge(),
              pick_edge(), pick_edge(), pick_edge(), pick_edge()};
      end
      default: begin
        // wide near-perpendicular pair around the origin
        r = pick(1, 32767);
        s = '{-r, pick(-r, r), r, pick(-r, r), pick(-r, r), -r, pick(-r, r), r};
      end
    endcase
    return s;
  endfunction

  task automatic send_pair(seg_pair_t s, bit fixed, bit meet);
    // random idle cycles with noise on two of the coordinate ports
    if (!steady && $urandom_range(99) < 13) begin
      start <= 1'b0;
      a_start_x <= coord_t'($urandom);
      b_end_y   <= coord_t'($urandom);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start     <= 1'b1;
    a_start_x <= coord_t'(s.ax0);
    a_start_y <= coord_t'(s.ay0);
    a_end_x   <= coord_t'(s.ax1);
    a_end_y   <= coord_t'(s.ay1);
    b_start_x <= coord_t'(s.bx0);
    b_start_y <= coord_t'(s.by0);
    b_end_x   <= coord_t'(s.bx1);
    b_end_y   <= coord_t'(s.by1);
    row_fixed <= fixed;
    row_meet  <= meet;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // record each accepted word and check each result word
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (done) begin
        if (meet_expected.size() == 0) begin
          $display("%0t: segments_meet word %0b arrived with nothing expected",
                   $time, segments_meet);
          errors++;
        end else begin
          want = meet_expected.pop_front();
          results_checked++;
          if (segments_meet) meets_seen++;
          if (segments_meet !== want) begin
            $display("%0t: segments_meet expected %0b actual %0b", $time, want, segments_meet);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (row_fixed) want = row_meet;
        else want = pair_meets(a_start_x, a_start_y, a_end_x, a_end_y,
                               b_start_x, b_start_y, b_end_x, b_end_y);
        meet_expected = {meet_expected, want};
      end
    end
  end

  // main sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    foreach (plan[i]) send_pair(plan[i].seg, plan[i].fixed, plan[i].meet);

    // random pairs, with one long stretch of back-to-back words
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      steady = (n >= 300 && n < 500);
      send_pair(random_pair(), 1'b0, 1'b0);
    end
    start <= 1'b0;

    // drain the pipeline
    while (meet_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d directed and %0d random segment pairs, %0d results checked",
             DIRECTED_ROWS, RANDOM_PAIRS, results_checked);
    $display("%0d pairs met, %0d did not, %0d mismatches",
             meets_seen, results_checked - meets_seen, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
